### hw/rtl/matrix_point_set_rect_sum_top_assert.svh
// Assertion macros for the matrix point-set / rectangle-sum block.
// Depends on nothing; included by files that check their own logic.
`ifndef MATRIX_POINT_SET_RECT_SUM_TOP_ASSERT_SVH
`define MATRIX_POINT_SET_RECT_SUM_TOP_ASSERT_SVH
// Implication checked at every clock edge, disabled while reset is low.
`define MPSRS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Condition that must never hold outside reset.
`define MPSRS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`endif

### hw/rtl/mpsrs_pkg.sv
// Shared widths, opcodes and controller states of the matrix sum block.
// No dependencies.
package mpsrs_pkg;
  localparam int OPCODE_W = 2;
  localparam int COORD_W  = 8;
  localparam int VALUE_W  = 32;
  localparam int TOTAL_W  = 64;
  localparam int SIZE_W   = 9;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;

  typedef enum logic [OPCODE_W-1:0] {
    OP_SET = 2'd0,
    OP_SUM = 2'd1,
    OP_CLR = 2'd2
  } opcode_t;

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_CLR   = 9'b000000010,
    ST_SH_RD = 9'b000000100,
    ST_SH_WB = 9'b000001000,
    ST_UP_RD = 9'b000010000,
    ST_UP_WR = 9'b000100000,
    ST_SUM   = 9'b001000000,
    ST_DRAIN = 9'b010000000,
    ST_EMIT  = 9'b100000000
  } state_t;
endpackage

### hw/rtl/mpsrs_in_if.sv
// Input channel: valid/ready handshake with the item fields.
// Depends on mpsrs_pkg.
interface mpsrs_in_if;
  import mpsrs_pkg::*;
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [COORD_W-1:0]  row;
  logic [COORD_W-1:0]  col;
  logic [COORD_W-1:0]  row_end;
  logic [COORD_W-1:0]  col_end;
  logic signed [VALUE_W-1:0] new_value;
  modport source (output valid, opcode, row, col, row_end, col_end, new_value,
                  input ready);
  modport sink   (input valid, opcode, row, col, row_end, col_end, new_value,
                  output ready);
endinterface

### hw/rtl/mpsrs_out_if.sv
// Result channel: valid/ready handshake with total and error flag.
// Depends on mpsrs_pkg.
interface mpsrs_out_if;
  import mpsrs_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [TOTAL_W-1:0] total;
  logic                      bad_coordinate;
  modport source (output valid, total, bad_coordinate, input ready);
  modport sink   (input valid, total, bad_coordinate, output ready);
endinterface

### hw/rtl/mpsrs_ram.sv
// Generic single-write, single-read synchronous RAM, registered read.
// No dependencies.
module mpsrs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### hw/rtl/matrix_point_set_rect_sum_top.sv
// Square matrix of signed 32-bit cells with point writes and rectangle sums,
// held as a cell shadow RAM and a 2-D Fenwick tree RAM (one read, one write
// port each, registered read). One transaction is worked at a time.
// A set goes through accept, shadow read and shadow write-back, then visits
// the tree nodes on its update path (at most (log2(MAX_SIDE)+1)^2): each node is
// a read then a write-back through the tree RAM. A sum issues one tree read
// per cycle over its four prefix queries; a prefix walk from (i, j) visits
// popcount(i)*popcount(j) nodes, at most log2(MAX_SIDE)^2, so a sum takes at
// most 4*log2(MAX_SIDE)^2 nodes (256 at side 256), then passes drain
// and emit. A bad coordinate goes from accept straight to emit. A result
// also holds in emit while the output register is still full. A clear item,
// and reset, sweep both RAMs one entry a cycle, during which no input
// transaction is taken; configuration writes are taken at any time. The
// output register lets the next input transaction in while a result still
// waits on the output.
// Depends on mpsrs_pkg, mpsrs_in_if, mpsrs_out_if and mpsrs_ram.
`include "matrix_point_set_rect_sum_top_assert.svh"

module matrix_point_set_rect_sum_top #(
  parameter int MAX_SIDE = 256
) (
  input  logic                       clk,
  input  logic                       rst_n,
  mpsrs_in_if.sink                   in_if,
  mpsrs_out_if.source                out_if,
  input  logic                       cfg_we,
  input  logic [mpsrs_pkg::SIZE_W-1:0] cfg_wdata
);
  import mpsrs_pkg::*;

  localparam int DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam int IW    = $clog2(MAX_SIDE + 1);   // Fenwick index 1..MAX_SIDE
  localparam int CMPW  = (IW > SIZE_W) ? IW : SIZE_W;

  // Flat RAM address of 1-based node (i, j).
  function automatic logic [AW-1:0] node_addr(input logic [IW-1:0] i,
                                               input logic [IW-1:0] j);
    logic [AW-1:0] ri;
    logic [AW-1:0] cj;
    ri = AW'(i - 1'b1);
    cj = AW'(j - 1'b1);
    return AW'(ri * AW'(MAX_SIDE)) + cj;
  endfunction

  function automatic logic [IW:0] step_up(input logic [IW-1:0] v);
    logic [IW:0] ext;
    ext = {1'b0, v};
    return ext + (ext & (~ext + 1'b1));
  endfunction

  function automatic logic [IW-1:0] step_down(input logic [IW-1:0] v);
    return v & (v - 1'b1);
  endfunction

  // Registers
  state_t                 state_r, state_nxt;
  logic [SIZE_W-1:0]      size_r;
  logic [AW-1:0]          clr_addr_r, clr_addr_nxt;
  logic [IW-1:0]          i_r, i_nxt, j_r, j_nxt, j0_r, j0_nxt;
  logic [IW-1:0]          rl_r, rl_nxt, cl_r, cl_nxt, rh1_r, rh1_nxt, ch1_r, ch1_nxt;
  logic [1:0]             qsel_r, qsel_nxt;
  logic [VALUE_W-1:0]     nv_r, nv_nxt;
  logic [TOTAL_W-1:0]     delta_r, delta_nxt;
  logic [TOTAL_W-1:0]     acc_r, acc_nxt;
  logic                   rd_vld_r, rd_vld_nxt, rd_neg_r, rd_neg_nxt;
  logic [TOTAL_W-1:0]     res_total_r, res_total_nxt;
  logic                   res_bad_r, res_bad_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [TOTAL_W-1:0]     out_total_r, out_total_nxt;
  logic                   out_bad_r, out_bad_nxt;

  // RAM ports
  logic               tree_we, sh_we;
  logic [AW-1:0]      tree_waddr, tree_raddr, sh_addr;
  logic [TOTAL_W-1:0] tree_wdata, tree_rdata;
  logic [VALUE_W-1:0] sh_wdata, sh_rdata;

  mpsrs_ram #(.WIDTH(TOTAL_W), .DEPTH(DEPTH)) u_tree_ram (
    .clk(clk), .we(tree_we), .waddr(tree_waddr), .wdata(tree_wdata),
    .raddr(tree_raddr), .rdata(tree_rdata)
  );

  mpsrs_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_shadow_ram (
    .clk(clk), .we(sh_we), .waddr(sh_addr), .wdata(sh_wdata),
    .raddr(sh_addr), .rdata(sh_rdata)
  );

  // Accepted coordinates must lie below min(size_in_use, MAX_SIDE).
  logic [CMPW-1:0] lim;
  logic            bad_rc, bad_ec;
  logic            in_fire, emit_load;
  logic [IW-1:0]   in_r1, in_c1, in_r2, in_c2;
  logic [IW:0]     up_j, up_i;
  logic [IW-1:0]   dn_j, dn_i;
  logic [1:0]      qn;
  logic [IW-1:0]   qn_i0, qn_j0;

  assign lim = (CMPW'(size_r) < CMPW'(MAX_SIDE)) ? CMPW'(size_r) : CMPW'(MAX_SIDE);
  assign bad_rc = (CMPW'(in_if.row) >= lim) || (CMPW'(in_if.col) >= lim);
  assign bad_ec = (CMPW'(in_if.row_end) >= lim) || (CMPW'(in_if.col_end) >= lim);
  assign in_r1 = IW'(in_if.row);
  assign in_c1 = IW'(in_if.col);
  assign in_r2 = IW'(in_if.row_end);
  assign in_c2 = IW'(in_if.col_end);

  assign in_if.ready = (state_r == ST_IDLE);
  assign in_fire     = in_if.valid && in_if.ready;
  assign emit_load   = (state_r == ST_EMIT) && (!out_valid_r || out_if.ready);

  assign out_if.valid          = out_valid_r;
  assign out_if.total          = out_total_r;
  assign out_if.bad_coordinate = out_bad_r;

  assign up_j = step_up(j_r);
  assign up_i = step_up(i_r);
  assign dn_j = step_down(j_r);
  assign dn_i = step_down(i_r);

  // Start corner of the next prefix query: (+ hi,hi) (+ lo,lo) (- hi,lo) (- lo,hi).
  assign qn    = qsel_r + 2'd1;
  assign qn_i0 = qn[0] ? rl_r : rh1_r;
  assign qn_j0 = (qn == 2'd0 || qn == 2'd3) ? ch1_r : cl_r;

  // Accumulate returning tree reads in the cycle after the issue.
  always_comb begin
    acc_nxt = acc_r;
    if (rd_vld_r) begin
      acc_nxt = rd_neg_r ? (acc_r - tree_rdata) : (acc_r + tree_rdata);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    j0_nxt        = j0_r;
    rl_nxt        = rl_r;
    cl_nxt        = cl_r;
    rh1_nxt       = rh1_r;
    ch1_nxt       = ch1_r;
    qsel_nxt      = qsel_r;
    nv_nxt        = nv_r;
    delta_nxt     = delta_r;
    rd_vld_nxt    = 1'b0;
    rd_neg_nxt    = rd_neg_r;
    res_total_nxt = res_total_r;
    res_bad_nxt   = res_bad_r;
    tree_we       = 1'b0;
    tree_waddr    = node_addr(i_r, j_r);
    tree_wdata    = tree_rdata + delta_r;
    tree_raddr    = node_addr(i_r, j_r);
    sh_we         = 1'b0;
    sh_addr       = node_addr(i_r, j0_r);
    sh_wdata      = nv_r;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_if.opcode)
            OP_SET: begin
              if (bad_rc) begin
                res_total_nxt = '0;
                res_bad_nxt   = 1'b1;
                state_nxt     = ST_EMIT;
              end else begin
                i_nxt     = in_r1 + 1'b1;
                j_nxt     = in_c1 + 1'b1;
                j0_nxt    = in_c1 + 1'b1;
                nv_nxt    = in_if.new_value;
                state_nxt = ST_SH_RD;
              end
            end
            OP_SUM: begin
              if (bad_rc || bad_ec) begin
                res_total_nxt = '0;
                res_bad_nxt   = 1'b1;
                state_nxt     = ST_EMIT;
              end else begin
                // Order the corners, then start at (hi+1, hi+1).
                rl_nxt    = (in_r1 < in_r2) ? in_r1 : in_r2;
                cl_nxt    = (in_c1 < in_c2) ? in_c1 : in_c2;
                rh1_nxt   = ((in_r1 < in_r2) ? in_r2 : in_r1) + 1'b1;
                ch1_nxt   = ((in_c1 < in_c2) ? in_c2 : in_c1) + 1'b1;
                i_nxt     = rh1_nxt;
                j_nxt     = ch1_nxt;
                j0_nxt    = ch1_nxt;
                qsel_nxt  = 2'd0;
                state_nxt = ST_SUM;
              end
            end
            OP_CLR: begin
              clr_addr_nxt = '0;
              state_nxt    = ST_CLR;
            end
            default: begin
            end
          endcase
        end
      end
      ST_CLR: begin
        tree_we      = 1'b1;
        tree_waddr   = clr_addr_r;
        tree_wdata   = '0;
        sh_we        = 1'b1;
        sh_addr      = clr_addr_r;
        sh_wdata     = '0;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == AW'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SH_RD: begin
        state_nxt = ST_SH_WB;
      end
      ST_SH_WB: begin
        // Old value arrives: store the new one and hold the difference.
        sh_we     = 1'b1;
        delta_nxt = {{(TOTAL_W-VALUE_W){nv_r[VALUE_W-1]}}, nv_r}
                  - {{(TOTAL_W-VALUE_W){sh_rdata[VALUE_W-1]}}, sh_rdata};
        state_nxt = ST_UP_RD;
      end
      ST_UP_RD: begin
        state_nxt = ST_UP_WR;
      end
      ST_UP_WR: begin
        tree_we = 1'b1;
        if (up_j <= (IW+1)'(MAX_SIDE)) begin
          j_nxt     = IW'(up_j);
          state_nxt = ST_UP_RD;
        end else if (up_i <= (IW+1)'(MAX_SIDE)) begin
          i_nxt     = IW'(up_i);
          j_nxt     = j0_r;
          state_nxt = ST_UP_RD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SUM: begin
        if (i_r != '0 && j_r != '0) begin
          rd_vld_nxt = 1'b1;
          rd_neg_nxt = qsel_r[1];
        end
        if (i_r != '0 && j_r != '0 && dn_j != '0) begin
          j_nxt = dn_j;
        end else if (i_r != '0 && j_r != '0 && dn_i != '0) begin
          i_nxt = dn_i;
          j_nxt = j0_r;
        end else if (qsel_r == 2'd3) begin
          state_nxt = ST_DRAIN;
        end else begin
          // Advance to the next prefix query.
          qsel_nxt = qn;
          i_nxt    = qn_i0;
          j_nxt    = qn_j0;
          j0_nxt   = qn_j0;
        end
      end
      ST_DRAIN: begin
        res_total_nxt = acc_nxt;
        res_bad_nxt   = 1'b0;
        state_nxt     = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output register: load from the result, drop once taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_total_nxt = out_total_r;
    out_bad_nxt   = out_bad_r;
    if (emit_load) begin
      out_valid_nxt = 1'b1;
      out_total_nxt = res_total_r;
      out_bad_nxt   = res_bad_r;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;      // sweep both RAMs after reset
      clr_addr_r  <= '0;
      size_r      <= SIZE_RESET;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        size_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    i_r         <= i_nxt;
    j_r         <= j_nxt;
    j0_r        <= j0_nxt;
    rl_r        <= rl_nxt;
    cl_r        <= cl_nxt;
    rh1_r       <= rh1_nxt;
    ch1_r       <= ch1_nxt;
    qsel_r      <= qsel_nxt;
    nv_r        <= nv_nxt;
    delta_r     <= delta_nxt;
    rd_neg_r    <= rd_neg_nxt;
    res_total_r <= res_total_nxt;
    res_bad_r   <= res_bad_nxt;
    out_total_r <= out_total_nxt;
    out_bad_r   <= out_bad_nxt;
    acc_r       <= (state_r == ST_IDLE) ? '0 : acc_nxt;
  end

  `MPSRS_ASSERT_NEVER(a_no_tree_write_in_sum, tree_we && (state_r == ST_SUM || state_r == ST_DRAIN), "tree written during a sum")
  `MPSRS_ASSERT_IMPL(a_read_return_from_sum, rd_vld_r, $past(state_r) == ST_SUM, "tree read returned outside a sum")
  `MPSRS_ASSERT_IMPL(a_result_from_emit, $rose(out_valid_r), $past(state_r) == ST_EMIT, "result raised outside emit")
endmodule
